// ===== hdl/bfgim_pkg.sv =====
`default_nettype none

package bfgim_pkg;

   localparam int unsigned CoordWidth    = 12;
   localparam int unsigned IndexWidth    = 24;
   localparam int unsigned DirWidth      = 3;
   localparam int unsigned KindWidth     = 4;
   localparam int unsigned AreaWidth     = 2;
   localparam int unsigned CsrIndexWidth = 1;

   localparam int unsigned MaxCellsDefault = 4095;

   localparam logic [CoordWidth-1:0] CellsReset = CoordWidth'(64);
   localparam logic [CoordWidth-1:0] CellsXMin  = CoordWidth'(2);
   localparam logic [CoordWidth-1:0] CellsYMin  = CoordWidth'(1);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CELLS_X = 1'd0,
      CSR_CELLS_Y = 1'd1
   } csr_index_type;

   typedef enum logic [DirWidth-1:0] {
      DIR_NONE  = 3'd0,
      DIR_LEFT  = 3'd1,
      DIR_RIGHT = 3'd2,
      DIR_BELOW = 3'd3,
      DIR_ABOVE = 3'd4
   } dir_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_INTERIOR = 4'd0,
      KIND_LEFT     = 4'd1,
      KIND_RIGHT    = 4'd2,
      KIND_BOTTOM   = 4'd3,
      KIND_TOP      = 4'd4,
      KIND_BL       = 4'd5,
      KIND_TL       = 4'd6,
      KIND_BR       = 4'd7,
      KIND_TR       = 4'd8
   } kind_type;

   typedef enum logic [AreaWidth-1:0] {
      AREA_FULL    = 2'd0,
      AREA_HALF    = 2'd1,
      AREA_QUARTER = 2'd2
   } area_type;

endpackage

`default_nettype wire

// ===== hdl/bfgim_if.sv =====
`default_nettype none

interface bfgim_req_if;
   import bfgim_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [IndexWidth-1:0] node_index;
   logic [DirWidth-1:0]   direction;

   modport source (output valid, node_index, direction, input ready);
   modport sink   (input valid, node_index, direction, output ready);
endinterface

interface bfgim_rsp_if;
   import bfgim_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CoordWidth-1:0] column;
   logic [CoordWidth-1:0] row;
   logic [KindWidth-1:0]  node_kind;
   logic [AreaWidth-1:0]  area_class;
   logic [IndexWidth-1:0] neighbour_index;
   logic                  index_bad;
   logic                  neighbour_outside;

   modport source (output valid, column, row, node_kind, area_class, neighbour_index,
                   index_bad, neighbour_outside, input ready);
   modport sink   (input valid, column, row, node_kind, area_class, neighbour_index,
                   index_bad, neighbour_outside, output ready);
endinterface

`default_nettype wire

// ===== hdl/boundary_first_grid_index_mapper_top.sv =====
// Pipeline: 11 stages (input, class, six divider stages, position, product, output).
// Throughput: one beat per cycle while rsp is ready; on a stall, stages behind a bubble still advance.
// The depth is set by the 12-bit interior quotient: six radix-4 restoring divider stages.
// Reset (synchronous, active high): all stage valid bits clear, cells_x and cells_y
// return to 64 (clipped to the axis limit). Derived grid sizes are registered and settle in the cycle after.
`default_nettype none

module boundary_first_grid_index_mapper_top #(
   parameter int unsigned MAX_CELLS_PER_AXIS = bfgim_pkg::MaxCellsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   bfgim_req_if.sink                          req_if,
   bfgim_rsp_if.source                        rsp_if,
   input  logic                               csr_write_en,
   input  logic [bfgim_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bfgim_pkg::CoordWidth-1:0]   csr_data
);
   import bfgim_pkg::*;

   // Axis limit, capped by what a 12-bit register can hold.
   localparam int unsigned CoordMax = (2 ** CoordWidth) - 1;
   localparam int unsigned CapInt   = (MAX_CELLS_PER_AXIS > CoordMax) ? CoordMax
                                                                      : MAX_CELLS_PER_AXIS;
   localparam logic [CoordWidth-1:0] CellsCap = CoordWidth'(CapInt);

   localparam int unsigned TotalWidth = IndexWidth + 1;   // (nx+1)*(ny+1) reaches 2^24
   localparam int unsigned BndWidth   = CoordWidth + 2;   // 2*(nx+ny)
   localparam int unsigned SumWidth   = CoordWidth + 1;   // nx+ny

   // Stage map
   localparam int unsigned DivBits   = 2;
   localparam int unsigned DivStages = CoordWidth / DivBits;
   localparam int unsigned StgIn     = 0;
   localparam int unsigned StgClass  = 1;
   localparam int unsigned StgDiv0   = 2;
   localparam int unsigned StgPos    = StgDiv0 + DivStages;
   localparam int unsigned StgProd   = StgPos + 1;
   localparam int unsigned StgOut    = StgProd + 1;
   localparam int unsigned NumStages = StgOut + 1;

   // One record travels down the pipe; each stage fills in its part.
   typedef struct packed {
      logic [IndexWidth-1:0] k;
      logic [DirWidth-1:0]   dir;
      logic                  bad;
      logic                  inner;     // node lies in the interior block
      logic [CoordWidth-1:0] bcol;      // position when on the boundary ring
      logic [CoordWidth-1:0] brow;
      logic [IndexWidth-1:0] rem;       // divider partial remainder
      logic [CoordWidth-1:0] quo;       // divider quotient
      logic [CoordWidth-1:0] col;
      logic [CoordWidth-1:0] row;
      kind_type              kind;
      area_type              area;
      logic                  outside;
      logic                  has_nb;    // a real neighbor lookup is wanted
      logic                  nint;      // neighbor is an interior node
      logic [CoordWidth-1:0] ncol;
      logic [CoordWidth-1:0] nrow;
      logic [IndexWidth-1:0] prod;      // (nx-1)*(nrow-1)
      logic [IndexWidth-1:0] bidx;      // neighbor index when on the ring
      logic [IndexWidth-1:0] nidx;
   } stage_type;

   function automatic logic [CoordWidth-1:0] clamp_cells(input logic [CoordWidth-1:0] v,
                                                         input logic [CoordWidth-1:0] lo);
      logic [CoordWidth-1:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > CellsCap) r = CellsCap;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Grid size registers and derived sizes
   // ------------------------------------------------------------------
   logic [CoordWidth-1:0] nx_ff;
   logic [CoordWidth-1:0] ny_ff;
   logic [SumWidth-1:0]   xy_ff;     // nx+ny, start of top row
   logic [BndWidth-1:0]   bnd2_ff;   // 2nx+ny, start of left column
   logic [BndWidth-1:0]   nb_ff;     // boundary node count
   logic [TotalWidth-1:0] total_ff;  // node count
   logic [CoordWidth-1:0] d_ff;      // interior nodes per row

   logic [SumWidth-1:0]     xy_sum;
   logic [SumWidth-1:0]     nx_p1;
   logic [SumWidth-1:0]     ny_p1;
   logic [2*SumWidth-1:0]   total_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff <= clamp_cells(CellsReset, CellsXMin);
         ny_ff <= clamp_cells(CellsReset, CellsYMin);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CELLS_X: nx_ff <= clamp_cells(csr_data, CellsXMin);
            CSR_CELLS_Y: ny_ff <= clamp_cells(csr_data, CellsYMin);
            default: ;
         endcase
      end
   end

   assign xy_sum     = {1'b0, nx_ff} + {1'b0, ny_ff};
   assign nx_p1      = {1'b0, nx_ff} + SumWidth'(1);
   assign ny_p1      = {1'b0, ny_ff} + SumWidth'(1);
   assign total_full = (2*SumWidth)'(nx_p1) * (2*SumWidth)'(ny_p1);

   always_ff @(posedge clock) begin
      xy_ff    <= xy_sum;
      bnd2_ff  <= BndWidth'(xy_sum) + BndWidth'(nx_ff);
      nb_ff    <= {xy_sum, 1'b0};
      total_ff <= total_full[TotalWidth-1:0];
      d_ff     <= nx_ff - CoordWidth'(1);
   end

   // ------------------------------------------------------------------
   // Pipeline control: a stage loads when the output drains or any stage
   // from it to the output is empty.
   // ------------------------------------------------------------------
   logic [NumStages-1:0] v_ff;
   logic [NumStages-1:0] v_in;
   logic [NumStages-1:0] v_prev;
   logic [NumStages-1:0] stg_ready;
   stage_type            p_ff [NumStages];
   stage_type            p_in [NumStages];

   always_comb begin
      for (int i = 0; i < NumStages; i++) begin
         stg_ready[i] = rsp_if.ready ||
                        ((v_ff | NumStages'((64'd1 << i) - 64'd1)) != {NumStages{1'b1}});
      end
   end

   assign v_prev = {v_ff[NumStages-2:0], req_if.valid};
   assign v_in   = (stg_ready & v_prev) | (~stg_ready & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NumStages; i++) begin
         if (stg_ready[i]) p_ff[i] <= p_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage logic
   // ------------------------------------------------------------------
   stage_type             s;
   logic [IndexWidth-1:0] diff_r1;   // k - nx
   logic [IndexWidth-1:0] diff_r2;   // 2nx+ny - k
   logic [IndexWidth-1:0] diff_r3;   // nb - k
   logic [IndexWidth-1:0] trial;
   int                    div_pos;
   logic                  at_l, at_r, at_b, at_t;
   logic [CoordWidth-1:0] nrow_dec;

   always_comb begin
      // input capture
      s       = '0;
      s.k     = req_if.node_index;
      s.dir   = req_if.direction;
      p_in[StgIn] = s;

      // range check and boundary ring decode
      s       = p_ff[StgIn];
      diff_r1 = s.k - IndexWidth'(nx_ff);
      diff_r2 = IndexWidth'(bnd2_ff) - s.k;
      diff_r3 = IndexWidth'(nb_ff) - s.k;
      s.bad   = ({1'b0, s.k} >= total_ff);
      s.inner = 1'b0;
      s.quo   = '0;
      s.rem   = s.k - IndexWidth'(nb_ff);
      if (s.k < IndexWidth'(nx_ff)) begin              // bottom row, going right
         s.bcol = s.k[CoordWidth-1:0];
         s.brow = '0;
      end else if (s.k < IndexWidth'(xy_ff)) begin     // right column, going up
         s.bcol = nx_ff;
         s.brow = diff_r1[CoordWidth-1:0];
      end else if (s.k < IndexWidth'(bnd2_ff)) begin   // top row, going left
         s.bcol = diff_r2[CoordWidth-1:0];
         s.brow = ny_ff;
      end else if (s.k < IndexWidth'(nb_ff)) begin     // left column, going down
         s.bcol = '0;
         s.brow = diff_r3[CoordWidth-1:0];
      end else begin
         s.bcol  = '0;
         s.brow  = '0;
         s.inner = 1'b1;
      end
      p_in[StgClass] = s;

      // interior offset / (nx-1), radix-4 restoring, two quotient bits a stage
      trial   = '0;
      div_pos = 0;
      for (int j = 0; j < DivStages; j++) begin
         s = p_ff[StgDiv0 + j - 1];
         for (int b = 0; b < DivBits; b++) begin
            div_pos = int'(CoordWidth) - 1 - j * int'(DivBits) - b;
            trial   = IndexWidth'(d_ff) << div_pos;
            if (s.rem >= trial) begin
               s.rem          = s.rem - trial;
               s.quo[div_pos] = 1'b1;
            end
         end
         p_in[StgDiv0 + j] = s;
      end

      // position, kind, area, neighbor coordinates
      s = p_ff[StgPos - 1];
      if (s.inner) begin
         s.col = s.rem[CoordWidth-1:0] + CoordWidth'(1);
         s.row = s.quo + CoordWidth'(1);
      end else begin
         s.col = s.bcol;
         s.row = s.brow;
      end
      at_l = (s.col == '0);
      at_r = (s.col == nx_ff);
      at_b = (s.row == '0);
      at_t = (s.row == ny_ff);
      if (at_l) begin
         s.kind = at_b ? KIND_BL : (at_t ? KIND_TL : KIND_LEFT);
      end else if (at_r) begin
         s.kind = at_b ? KIND_BR : (at_t ? KIND_TR : KIND_RIGHT);
      end else if (at_b) begin
         s.kind = KIND_BOTTOM;
      end else if (at_t) begin
         s.kind = KIND_TOP;
      end else begin
         s.kind = KIND_INTERIOR;
      end
      if ((at_l || at_r) && (at_b || at_t)) s.area = AREA_QUARTER;
      else if (at_l || at_r || at_b || at_t) s.area = AREA_HALF;
      else s.area = AREA_FULL;

      s.ncol    = s.col;
      s.nrow    = s.row;
      s.outside = 1'b0;
      s.has_nb  = 1'b0;
      case (s.dir)
         DIR_LEFT: begin
            if (at_l) s.outside = 1'b1;
            else begin
               s.has_nb = 1'b1;
               s.ncol   = s.col - CoordWidth'(1);
            end
         end
         DIR_RIGHT: begin
            if (at_r) s.outside = 1'b1;
            else begin
               s.has_nb = 1'b1;
               s.ncol   = s.col + CoordWidth'(1);
            end
         end
         DIR_BELOW: begin
            if (at_b) s.outside = 1'b1;
            else begin
               s.has_nb = 1'b1;
               s.nrow   = s.row - CoordWidth'(1);
            end
         end
         DIR_ABOVE: begin
            if (at_t) s.outside = 1'b1;
            else begin
               s.has_nb = 1'b1;
               s.nrow   = s.row + CoordWidth'(1);
            end
         end
         default: ;   // none, and codes with no meaning
      endcase
      p_in[StgPos] = s;

      // neighbor: ring index, or the row product for an interior neighbor
      s        = p_ff[StgProd - 1];
      nrow_dec = s.nrow - CoordWidth'(1);
      s.prod   = IndexWidth'(d_ff) * IndexWidth'(nrow_dec);
      s.nint   = 1'b0;
      if (s.nrow == '0) begin
         s.bidx = IndexWidth'(s.ncol);
      end else if (s.ncol == nx_ff) begin
         s.bidx = IndexWidth'(s.nrow) + IndexWidth'(nx_ff);
      end else if (s.nrow == ny_ff) begin
         s.bidx = IndexWidth'(bnd2_ff) - IndexWidth'(s.ncol);
      end else if (s.ncol == '0) begin
         s.bidx = IndexWidth'(nb_ff) - IndexWidth'(s.nrow);
      end else begin
         s.bidx = '0;
         s.nint = 1'b1;
      end
      p_in[StgProd] = s;

      // final index and bad-index squash
      s = p_ff[StgOut - 1];
      if (!s.has_nb) s.nidx = s.k;
      else if (s.nint) s.nidx = IndexWidth'(nb_ff) + s.prod + IndexWidth'(s.ncol)
                                - IndexWidth'(1);
      else s.nidx = s.bidx;
      if (s.bad) begin
         s.col     = '0;
         s.row     = '0;
         s.kind    = KIND_INTERIOR;
         s.area    = AREA_FULL;
         s.nidx    = '0;
         s.outside = 1'b0;
      end
      p_in[StgOut] = s;
   end

   // ------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------
   assign req_if.ready             = stg_ready[StgIn];
   assign rsp_if.valid             = v_ff[StgOut];
   assign rsp_if.column            = p_ff[StgOut].col;
   assign rsp_if.row               = p_ff[StgOut].row;
   assign rsp_if.node_kind         = p_ff[StgOut].kind;
   assign rsp_if.area_class        = p_ff[StgOut].area;
   assign rsp_if.neighbour_index   = p_ff[StgOut].nidx;
   assign rsp_if.index_bad         = p_ff[StgOut].bad;
   assign rsp_if.neighbour_outside = p_ff[StgOut].outside;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_bad_zeroed: assert property (@(posedge clock) disable iff (reset)
      (v_ff[StgOut] && p_ff[StgOut].bad) |->
         (p_ff[StgOut].col == '0 && p_ff[StgOut].row == '0 &&
          p_ff[StgOut].nidx == '0 && !p_ff[StgOut].outside))
      else $error("bad index beat carries nonzero fields");

   a_area_kind: assert property (@(posedge clock) disable iff (reset)
      (v_ff[StgOut] && !p_ff[StgOut].bad) |->
         ((p_ff[StgOut].area == AREA_FULL) == (p_ff[StgOut].kind == KIND_INTERIOR)))
      else $error("area class disagrees with node kind");

   a_on_grid: assert property (@(posedge clock) disable iff (reset)
      (v_ff[StgOut] && !p_ff[StgOut].bad) |->
         (p_ff[StgOut].col <= nx_ff && p_ff[StgOut].row <= ny_ff))
      else $error("decoded position off the grid");

   a_dir_none: assert property (@(posedge clock) disable iff (reset)
      (v_ff[StgOut] && !p_ff[StgOut].bad && p_ff[StgOut].dir == DIR_NONE) |->
         (!p_ff[StgOut].outside && p_ff[StgOut].nidx == p_ff[StgOut].k))
      else $error("no-direction beat does not return its own index");

endmodule

`default_nettype wire
